// File: hdl/ist_pkg.sv
// ist_pkg: shared types for the insertion sorter
// controller states and the command and status words between controller and datapath
// no dependencies
`default_nettype none

package ist_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CMP,
        S_PUT,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    typedef struct packed {
        logic take_in;      // latch the input word
        logic pos_from_fill;
        logic set_ovf;
        logic rd_shift;     // read the entry below the insert point
        logic shift;        // move the entry read up one place
        logic put;          // store the new value at the insert point
        logic emit_start;
        logic rd_emit;
        logic load_out;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic pos_zero;
        logic pos_one;
        logic greater;      // entry read is above the new value
        logic last;
        logic emit_final;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: hdl/insertion_sorter_core.sv
// insertion_sorter_core: top level of the insertion sorter
// depends on ist_pkg, ist_ctrl and ist_datapath
//
// input channel: value and last, with in_valid and in_stall. a word is taken
// when in_valid is high and in_stall low. each value is inserted into an
// ascending list kept in a ram with one write and one read port; equal values
// keep arrival order. an insert keeps in_stall high after acceptance while the
// held entries larger than the new value move up (one ram read and one write
// per moved entry, one entry per cycle) and the new value is then stored; into
// an empty list it is stored with no read, into a full one it is dropped.
// after the word marked last the list is read out on the output channel
// (sorted_value, end_of_block, overflowed with out_valid and out_stall),
// smallest first, each word read from the ram and then loaded into the output
// register while out_stall is low. end_of_block marks the largest.
// words beyond DEPTH are dropped and overflowed is set on that block's results.
// out_stall holds the output register; the next word of the block waits, and
// a new input word is taken while the final result still waits.
// reset clears the insert pointer, fill count, overflow flag and out_valid;
// the list ram is not cleared, no clearing pass is needed.
`default_nettype none

module insertion_sorter_core #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] value,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      sorted_value,
    output logic                    end_of_block,
    output logic                    overflowed
);

    import ist_pkg::*;

    cmd_t    cmd;
    status_t status;

    ist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ist_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .last         (last),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .sorted_value (sorted_value),
        .end_of_block (end_of_block),
        .overflowed   (overflowed),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

// File: hdl/ist_ram.sv
// ist_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/ist_ctrl.sv
// ist_ctrl: controller state machine of the insertion sorter
// depends on ist_pkg for state, command and status types
`default_nettype none

module ist_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire ist_pkg::status_t status,
    output ist_pkg::cmd_t         cmd
);

    import ist_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                priority if (status.full || status.pos_zero)
                begin
                    state_next = status.last ? S_EMIT_RD : S_IDLE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                priority if (status.greater)
                begin
                    state_next = status.pos_one ? S_PUT : S_CMP;
                end
                else
                begin
                    state_next = status.last ? S_EMIT_RD : S_IDLE;
                end
            end
            S_PUT:
            begin
                state_next = status.last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    state_next = status.emit_final ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall          = 1'b0;
                cmd.take_in       = in_valid;
                cmd.pos_from_fill = in_valid;
            end
            S_START:
            begin
                priority if (status.full)
                begin
                    cmd.set_ovf    = 1'b1;
                    cmd.emit_start = status.last;
                end
                else if (status.pos_zero)
                begin
                    cmd.put        = 1'b1;
                    cmd.emit_start = status.last;
                end
                else
                begin
                    cmd.rd_shift = 1'b1;
                end
            end
            S_CMP:
            begin
                priority if (status.greater)
                begin
                    cmd.shift    = 1'b1;
                    cmd.rd_shift = !status.pos_one;
                end
                else
                begin
                    cmd.put        = 1'b1;
                    cmd.emit_start = status.last;
                end
            end
            S_PUT:
            begin
                cmd.put        = 1'b1;
                cmd.emit_start = status.last;
            end
            S_EMIT_RD:
            begin
                cmd.rd_emit = 1'b1;
            end
            S_EMIT_LD:
            begin
                cmd.load_out = status.out_free;
                cmd.clear    = status.out_free && status.emit_final;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/ist_datapath.sv
// ist_datapath: list memory, insert pointer, fill count and output register
// depends on ist_pkg for command and status types, ist_ram for the list store
`default_nettype none

module ist_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic signed [31:0] value,
    input  wire logic               last,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic signed [31:0]      sorted_value,
    output logic                    end_of_block,
    output logic                    overflowed,
    input  wire ist_pkg::cmd_t      cmd,
    output ist_pkg::status_t        status
);

    import ist_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] value_reg;
    logic               last_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      pos_next;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      fill_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] sorted_value_reg;
    logic               end_of_block_reg;
    logic               overflowed_reg;

    logic               ram_we;
    logic [CW-1:0]      waddr_full;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [CW-1:0]      raddr_full;
    logic [31:0]        ram_rdata;
    logic [CW-1:0]      pos_inc;

    assign pos_inc = pos_reg + CW'(1);

    // write at the insert point: either the moved entry or the new value
    assign ram_we     = cmd.shift || cmd.put;
    assign waddr_full = pos_reg;
    assign ram_wdata  = cmd.shift ? ram_rdata : value_reg;
    assign ram_re     = cmd.rd_shift || cmd.rd_emit;

    // while shifting the pointer drops too, so look two places down
    always_comb
    begin
        priority if (cmd.rd_emit)
        begin
            raddr_full = pos_reg;
        end
        else if (cmd.shift)
        begin
            raddr_full = pos_reg - CW'(2);
        end
        else
        begin
            raddr_full = pos_reg - CW'(1);
        end
    end

    ist_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_full[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (raddr_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pos_next = pos_reg;
        priority if (cmd.pos_from_fill)
        begin
            pos_next = fill_reg;
        end
        else if (cmd.emit_start)
        begin
            pos_next = '0;
        end
        else if (cmd.shift)
        begin
            pos_next = pos_reg - CW'(1);
        end
        else if (cmd.load_out)
        begin
            pos_next = pos_inc;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        if (cmd.put)
        begin
            fill_next = fill_reg + CW'(1);
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.clear)
        begin
            fill_next = '0;
            ovf_next  = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            value_reg <= value;
            last_reg  <= last;
        end
        if (cmd.load_out)
        begin
            sorted_value_reg <= $signed(ram_rdata);
            end_of_block_reg <= (pos_inc == fill_reg);
            overflowed_reg   <= ovf_reg;
        end
    end

    assign status.full       = (fill_reg == CW'(DEPTH));
    assign status.pos_zero   = (pos_reg == '0);
    assign status.pos_one    = (pos_reg == CW'(1));
    assign status.greater    = ($signed(ram_rdata) > value_reg);
    assign status.last       = last_reg;
    assign status.emit_final = (pos_inc == fill_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign end_of_block = end_of_block_reg;
    assign overflowed   = overflowed_reg;

endmodule

`default_nettype wire

// File: hdl/ist_checker.sv
// ist_checker: port level assertions for insertion_sorter_core
// bound to the top level below; no package dependencies
`default_nettype none

module ist_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] sorted_value,
    input wire logic        end_of_block,
    input wire logic        overflowed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sorted_value) && $stable(end_of_block)
            && $stable(overflowed))
        else $error("stalled output word changed");

    // in_stall is always high in the cycle after a word is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a word");

    // a word other than the final one means the readout is still running
    a_no_take_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_block |-> in_stall)
        else $error("input taken during readout");

endmodule

bind insertion_sorter_core ist_checker u_ist_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .end_of_block (end_of_block),
    .overflowed   (overflowed)
);

`default_nettype wire

// File: dv/insertion_sorter_core_tb.sv
// insertion_sorter_core_tb: self-checking testbench for the insertion sorter core
// predicts each sorted block with a stable insertion into a queue and checks every result word
// depends on insertion_sorter_core and the files below it only
module insertion_sorter_core_tb;

    localparam int DEPTH = 64;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_WORDS = 50;
    localparam int QUIET_FROM = 35;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_block;
        logic               overflowed;
    } sorted_word_t;

    class block_sort_checker;
        int unsigned        depth;
        logic signed [31:0] held[$];
        bit                 dropped;
        sorted_word_t       sorted_due[$];
        int unsigned        errors;
        int unsigned        words_taken;
        int unsigned        results_checked;
        int unsigned        blocks_closed;
        int unsigned        overflow_blocks;

        function new(int unsigned d);
            depth = d;
        endfunction

        // stable insert: only entries strictly greater move up
        function void take_word(logic signed [31:0] v, logic l);
            int pos;
            sorted_word_t w;
            words_taken++;
            if (held.size() >= depth) begin
                dropped = 1'b1;
            end
            else begin
                pos = held.size();
                while (pos > 0 && held[pos - 1] > v)
                    pos--;
                held.insert(pos, v);
            end
            if (l) begin
                foreach (held[k]) begin
                    w.sorted_value = held[k];
                    w.end_of_block = (k == held.size() - 1);
                    w.overflowed   = dropped;
                    sorted_due.insert(sorted_due.size(), w);
                end
                blocks_closed++;
                if (dropped)
                    overflow_blocks++;
                held.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_word(logic signed [31:0] v, logic eob, logic ovf);
            sorted_word_t w;
            if (sorted_due.size() == 0) begin
                $error("result word %0d with none expected", v);
                errors++;
                return;
            end
            w = sorted_due.pop_front();
            results_checked++;
            if (v !== w.sorted_value) begin
                $error("sorted_value: expected %0d, got %0d", w.sorted_value, v);
                errors++;
            end
            if (eob !== w.end_of_block) begin
                $error("end_of_block: expected %0b, got %0b", w.end_of_block, eob);
                errors++;
            end
            if (ovf !== w.overflowed) begin
                $error("overflowed: expected %0b, got %0b", w.overflowed, ovf);
                errors++;
            end
        endfunction

        function void close_run();
            if (sorted_due.size() != 0) begin
                $error("%0d result words never arrived", sorted_due.size());
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] value;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] sorted_value;
    logic               end_of_block;
    logic               overflowed;

    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    block_sort_checker sb = new(DEPTH);

    insertion_sorter_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sorted_value(sorted_value),
        .end_of_block(end_of_block),
        .overflowed  (overflowed)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_word(sorted_value, end_of_block, overflowed);
            if (in_valid && !in_stall)
                sb.take_word(value, last);
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stall_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom_range(0, 15) - 8;   // narrow range gives duplicates
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       v = VAL_MAX;
                    1:       v = VAL_MIN;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // called and returns at a falling edge
    task automatic send_word(input logic signed [31:0] v, input logic l);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_batch(input logic signed [31:0] vals[$]);
        foreach (vals[i])
            send_word(vals[i], i == vals.size() - 1);
    endtask

    task automatic send_block(input int n);
        for (int i = 0; i < n; i++)
            send_word(pick_value(), i == n - 1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.sorted_due.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic signed [31:0] batch[$];
        int n;
        int random_words;
        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        last = 1'b0;
        random_words = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // one-word blocks at the extremes
        send_word(VAL_MAX, 1'b1);
        send_word(VAL_MIN, 1'b1);
        batch = '{32'sd0, -32'sd1, 32'sd1, VAL_MAX, VAL_MIN};
        send_batch(batch);
        // equal values keep arrival order
        batch = '{32'sd7, -32'sd2, 32'sd7, 32'sd7, -32'sd2};
        send_batch(batch);
        // descending input moves every held entry
        batch = '{32'sd40, 32'sd30, 32'sd20, 32'sd10, 32'sd0, -32'sd10, -32'sd20};
        send_batch(batch);
        batch = '{32'sd1, 32'sd2, 32'sd3};
        send_batch(batch);
        drain();

        // exactly full, then two dropped including the last word
        send_block(DEPTH);
        send_block(DEPTH + 2);
        drain();

        // long output hold while words keep coming
        hold_req = 1'b1;
        while (random_words < RANDOM_WORDS)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            if (random_words >= QUIET_FROM)
                quiet = 1'b1;
            send_block(n);
            random_words += n;
        end
        in_valid <= 1'b0;

        while (sb.sorted_due.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        sb.close_run();

        $display("%0d words in %0d blocks (%0d with dropped words), %0d result words checked",
                 sb.words_taken, sb.blocks_closed, sb.overflow_blocks, sb.results_checked);
        $display("covered extremes, duplicates, full and overflowing lists, a long output hold");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: insertion_sorter_core.f
hdl/ist_pkg.sv
hdl/ist_ram.sv
hdl/ist_ctrl.sv
hdl/ist_datapath.sv
hdl/insertion_sorter_core.sv
hdl/ist_checker.sv
dv/insertion_sorter_core_tb.sv
